[hdl/bfcp_pkg.sv]
// ----------------------------------------------------------------------------
// bfcp_pkg: shared types and constants of the best-fit chunk packer
// Field widths, register indexes, result codes and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfcp_pkg;

    localparam int CAP_W      = 21;
    localparam int THR_W      = 16;
    localparam int STRIPE_W   = 32;
    localparam int SLOT_OUT_W = 6;
    localparam int CHK_W      = CAP_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(4096);
    localparam logic [CHK_W-1:0] HEADER_BYTES = CHK_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_CAPACITY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_STRIPE_ID = 2'd2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;
    localparam logic KIND_FLUSH = 1'b0;
    localparam logic KIND_GRANT = 1'b1;

    typedef struct packed {
        logic cfg_we;
        logic load;
        logic scan;
        logic select;
        logic flush;
        logic grant;
        logic last;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic found;
        logic op_flush;
        logic need_flush;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/bfcp_datapath.sv]
// ----------------------------------------------------------------------------
// bfcp_datapath: slot state, scan unit and result register
// Holds the slot fill levels and stripe numbers, walks the slots one per
// cycle to find the best fit and the fullest slot, and applies grants and
// flushes to the slot selected as target.
// ----------------------------------------------------------------------------
module bfcp_datapath #(
    parameter int NUM_CHUNKS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bfcp_pkg::dp_cmd_t                 cmd,
    output bfcp_pkg::dp_status_t              status,
    input  logic                              op,
    input  logic [bfcp_pkg::CAP_W-1:0]        req_size,
    input  logic [bfcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfcp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              kind,
    output logic [bfcp_pkg::STRIPE_W-1:0]     stripe_id,
    output logic [bfcp_pkg::SLOT_OUT_W-1:0]   slot,
    output logic [bfcp_pkg::CAP_W-1:0]        offset,
    output logic                              last
);

    localparam int SLOT_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    logic [bfcp_pkg::CAP_W-1:0]    fill_reg   [NUM_CHUNKS];
    logic [bfcp_pkg::STRIPE_W-1:0] stripe_reg [NUM_CHUNKS];
    logic [bfcp_pkg::STRIPE_W-1:0] next_stripe_reg;
    logic [bfcp_pkg::CAP_W-1:0]    cap_reg;
    logic [bfcp_pkg::THR_W-1:0]    thr_reg;

    logic [SLOT_W-1:0]             idx_reg;
    logic                          found_reg;
    logic                          out_valid_reg;

    logic                          op_reg;
    logic [bfcp_pkg::CAP_W-1:0]    size_reg;
    logic [bfcp_pkg::CAP_W:0]      fit_after_reg;
    logic [SLOT_W-1:0]             fit_slot_reg;
    logic [bfcp_pkg::CAP_W-1:0]    fit_fill_reg;
    logic [bfcp_pkg::STRIPE_W-1:0] fit_stripe_reg;
    logic [SLOT_W-1:0]             full_slot_reg;
    logic [bfcp_pkg::CAP_W-1:0]    full_fill_reg;
    logic [bfcp_pkg::STRIPE_W-1:0] full_stripe_reg;
    logic [SLOT_W-1:0]             tgt_slot_reg;
    logic [bfcp_pkg::CAP_W-1:0]    tgt_fill_reg;
    logic [bfcp_pkg::STRIPE_W-1:0] tgt_stripe_reg;

    logic                          kind_reg;
    logic [bfcp_pkg::STRIPE_W-1:0] stripe_id_reg;
    logic [bfcp_pkg::SLOT_OUT_W-1:0] slot_reg;
    logic [bfcp_pkg::CAP_W-1:0]    offset_reg;
    logic                          last_reg;

    logic [bfcp_pkg::CAP_W-1:0]    rd_fill;
    logic [bfcp_pkg::STRIPE_W-1:0] rd_stripe;
    logic [bfcp_pkg::CAP_W:0]      after;
    logic                          fits;
    logic                          fit_take;
    logic                          full_take;
    logic [bfcp_pkg::CAP_W-1:0]    new_fill;
    logic [bfcp_pkg::CHK_W-1:0]    chk_sum;

    assign rd_fill   = fill_reg[idx_reg];
    assign rd_stripe = stripe_reg[idx_reg];
    assign after     = {1'b0, rd_fill} + {1'b0, size_reg};
    assign fits      = after <= {1'b0, cap_reg};
    assign fit_take  = fits && ((after > fit_after_reg) ||
                       ((after == fit_after_reg) && found_reg &&
                        (rd_stripe < fit_stripe_reg)));
    assign full_take = (idx_reg == '0) || (rd_fill > full_fill_reg) ||
                       ((rd_fill == full_fill_reg) && (rd_stripe < full_stripe_reg));

    assign new_fill  = tgt_fill_reg + size_reg;
    assign chk_sum   = {2'b00, new_fill} + bfcp_pkg::HEADER_BYTES +
                       {{(bfcp_pkg::CHK_W - bfcp_pkg::THR_W){1'b0}}, thr_reg};

    assign status.scan_last  = idx_reg == SLOT_W'(NUM_CHUNKS - 1);
    assign status.found      = found_reg;
    assign status.op_flush   = op_reg == bfcp_pkg::OP_FLUSH;
    assign status.need_flush = chk_sum >= {2'b00, cap_reg};
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign stripe_id = stripe_id_reg;
    assign slot      = slot_reg;
    assign offset    = offset_reg;
    assign last      = last_reg;

    // Slot state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                fill_reg[i]   <= '0;
                stripe_reg[i] <= bfcp_pkg::STRIPE_W'(i);
            end
            next_stripe_reg <= bfcp_pkg::STRIPE_W'(NUM_CHUNKS);
            cap_reg         <= bfcp_pkg::CAP_RESET;
            thr_reg         <= '0;
        end
        else
        begin
            priority if (cmd.cfg_we)
            begin
                unique case (cfg_index)
                    bfcp_pkg::CFG_CHUNK_CAPACITY:
                    begin
                        cap_reg <= cfg_data[bfcp_pkg::CAP_W-1:0];
                    end
                    bfcp_pkg::CFG_FLUSH_THRESHOLD:
                    begin
                        thr_reg <= cfg_data[bfcp_pkg::THR_W-1:0];
                    end
                    bfcp_pkg::CFG_FIRST_STRIPE_ID:
                    begin
                        for (int i = 0; i < NUM_CHUNKS; i++)
                        begin
                            fill_reg[i]   <= '0;
                            stripe_reg[i] <= cfg_data + bfcp_pkg::STRIPE_W'(i);
                        end
                        next_stripe_reg <= cfg_data + bfcp_pkg::STRIPE_W'(NUM_CHUNKS);
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.flush)
            begin
                fill_reg[tgt_slot_reg]   <= '0;
                stripe_reg[tgt_slot_reg] <= next_stripe_reg;
                next_stripe_reg          <= next_stripe_reg + bfcp_pkg::STRIPE_W'(1);
            end
            else if (cmd.grant)
            begin
                fill_reg[tgt_slot_reg] <= new_fill;
            end
        end
    end

    // Scan index, candidate flag and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (fit_take)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.flush || cmd.grant)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request, candidate, target and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op;
            size_reg      <= req_size;
            fit_after_reg <= '0;
        end

        if (cmd.scan)
        begin
            if (fit_take)
            begin
                fit_after_reg  <= after;
                fit_slot_reg   <= idx_reg;
                fit_fill_reg   <= rd_fill;
                fit_stripe_reg <= rd_stripe;
            end
            if (full_take)
            begin
                full_slot_reg   <= idx_reg;
                full_fill_reg   <= rd_fill;
                full_stripe_reg <= rd_stripe;
            end
        end

        if (cmd.select)
        begin
            if (found_reg && (op_reg == bfcp_pkg::OP_ALLOC))
            begin
                tgt_slot_reg   <= fit_slot_reg;
                tgt_fill_reg   <= fit_fill_reg;
                tgt_stripe_reg <= fit_stripe_reg;
            end
            else
            begin
                tgt_slot_reg   <= full_slot_reg;
                tgt_fill_reg   <= full_fill_reg;
                tgt_stripe_reg <= full_stripe_reg;
            end
        end
        else if (cmd.flush)
        begin
            tgt_fill_reg   <= '0;
            tgt_stripe_reg <= next_stripe_reg;
        end

        if (cmd.flush)
        begin
            kind_reg      <= bfcp_pkg::KIND_FLUSH;
            stripe_id_reg <= tgt_stripe_reg;
            slot_reg      <= bfcp_pkg::SLOT_OUT_W'(tgt_slot_reg);
            offset_reg    <= '0;
            last_reg      <= cmd.last;
        end
        else if (cmd.grant)
        begin
            kind_reg      <= bfcp_pkg::KIND_GRANT;
            stripe_id_reg <= tgt_stripe_reg;
            slot_reg      <= bfcp_pkg::SLOT_OUT_W'(tgt_slot_reg);
            offset_reg    <= tgt_fill_reg;
            last_reg      <= cmd.last;
        end
    end

endmodule

[hdl/bfcp_ctrl.sv]
// ----------------------------------------------------------------------------
// bfcp_ctrl: request sequencer of the best-fit chunk packer
// Accepts a request, runs the slot scan, picks the target slot and issues
// the flush and grant results in order as the result register frees up.
// ----------------------------------------------------------------------------
module bfcp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bfcp_pkg::dp_status_t status,
    output bfcp_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_SELECT  = 3'd2;
    localparam logic [2:0] ST_FLUSH_A = 3'd3;
    localparam logic [2:0] ST_GRANT   = 3'd4;
    localparam logic [2:0] ST_FLUSH_B = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = !cfg_valid;
                cfg_ready  = 1'b1;
                cmd.cfg_we = cfg_valid;
                if (in_valid && !cfg_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                cmd.select = 1'b1;
                if (status.op_flush || !status.found)
                begin
                    state_next = ST_FLUSH_A;
                end
                else
                begin
                    state_next = ST_GRANT;
                end
            end
            ST_FLUSH_A:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    cmd.last   = status.op_flush;
                    state_next = status.op_flush ? ST_IDLE : ST_GRANT;
                end
            end
            ST_GRANT:
            begin
                if (status.out_free)
                begin
                    cmd.grant  = 1'b1;
                    cmd.last   = !status.need_flush;
                    state_next = status.need_flush ? ST_FLUSH_B : ST_IDLE;
                end
            end
            ST_FLUSH_B:
            begin
                if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/best_fit_chunk_packer.sv]
// ----------------------------------------------------------------------------
// best_fit_chunk_packer: best-fit packing of byte requests into chunk slots
// A request on the input channel either allocates req_size bytes (op 0) or
// flushes the fullest slot (op 1). Results leave on the output channel, one
// transfer each, with last set on the final result of a request: a flush
// request gives one flush event; an allocation gives an optional flush of
// the fullest slot when nothing fits, the grant, and an optional flush when
// the slot has become full. Configuration writes use their own channel
// (index 0 capacity, 1 flush threshold, 2 first stripe number, which clears
// and renumbers every slot) and are taken only while no request is open.
// A request is scanned over the slots one per cycle through the single slot
// read port; the target slot is then selected and each result is written to
// the output register in order. The block returns to idle after the last
// result is issued and only then takes the next request. When the receiver
// stalls, the result stays in the output register and the sequencer holds
// until it drains. Reset empties all slots, numbers slot i as i, and
// restores capacity 4096 and threshold 0.
// ----------------------------------------------------------------------------
module best_fit_chunk_packer #(
    parameter int NUM_CHUNKS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              op,
    input  logic [bfcp_pkg::CAP_W-1:0]        req_size,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bfcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfcp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              kind,
    output logic [bfcp_pkg::STRIPE_W-1:0]     stripe_id,
    output logic [bfcp_pkg::SLOT_OUT_W-1:0]   slot,
    output logic [bfcp_pkg::CAP_W-1:0]        offset,
    output logic                              last
);

    bfcp_pkg::dp_cmd_t    cmd;
    bfcp_pkg::dp_status_t status;

    bfcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bfcp_datapath #(
        .NUM_CHUNKS (NUM_CHUNKS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .req_size  (req_size),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .kind      (kind),
        .stripe_id (stripe_id),
        .slot      (slot),
        .offset    (offset),
        .last      (last)
    );

endmodule

[verif/tb_best_fit_chunk_packer.sv]
// ----------------------------------------------------------------------------
// tb_best_fit_chunk_packer: self-checking testbench of the best-fit packer
// A short table of directed requests and register writes runs first. Some
// rows carry hand-written results, and all other rows are checked against
// a packing predictor kept in the testbench. Six random phases follow, each
// under its own capacity, threshold and first stripe number; outside one calm
// phase both sides idle at random, and a watchdog ends a run that stalls.
// ----------------------------------------------------------------------------
module tb_best_fit_chunk_packer;

    localparam int NUM_CHUNKS = 8;
    localparam int N_DIR      = 28;
    localparam int IDLE_LIMIT = 2000;

    localparam logic [bfcp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                            kind;
        logic [bfcp_pkg::STRIPE_W-1:0]   stripe_id;
        logic [bfcp_pkg::SLOT_OUT_W-1:0] slot;
        logic [bfcp_pkg::CAP_W-1:0]      offset;
        logic                            last;
    } result_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                       rk;
        logic [bfcp_pkg::CFG_IDX_W-1:0]  idx;
        logic [bfcp_pkg::CFG_DATA_W-1:0] data;
        logic                            op;
        logic [bfcp_pkg::CAP_W-1:0]      size;
        logic [1:0]                      n_want;
        result_t [0:2]                   want;
    } row_t;

    localparam result_t NO_RES = '0;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic                            op        = bfcp_pkg::OP_ALLOC;
    logic [bfcp_pkg::CAP_W-1:0]      req_size  = '0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bfcp_pkg::CFG_IDX_W-1:0]  cfg_index = bfcp_pkg::CFG_CHUNK_CAPACITY;
    logic [bfcp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            kind;
    logic [bfcp_pkg::STRIPE_W-1:0]   stripe_id;
    logic [bfcp_pkg::SLOT_OUT_W-1:0] slot;
    logic [bfcp_pkg::CAP_W-1:0]      offset;
    logic                            last;

    logic [bfcp_pkg::CAP_W-1:0]    fill_lvl [NUM_CHUNKS];
    logic [bfcp_pkg::STRIPE_W-1:0] stripe_no [NUM_CHUNKS];
    logic [bfcp_pkg::STRIPE_W-1:0] stripe_ctr;
    logic [bfcp_pkg::STRIPE_W-1:0] base_stripe;
    logic [bfcp_pkg::CAP_W-1:0]    cap_reg;
    logic [bfcp_pkg::THR_W-1:0]    thr_reg;

    result_t pack_out [3];
    int      pack_n;
    result_t pack_events [$];

    row_t dir_tab [N_DIR];
    logic calm       = 1'b0;
    int   fail_count = 0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    best_fit_chunk_packer #(
        .NUM_CHUNKS(NUM_CHUNKS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .req_size  (req_size),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .stripe_id (stripe_id),
        .slot      (slot),
        .offset    (offset),
        .last      (last)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic row_t cfg_row(input logic [bfcp_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [bfcp_pkg::CFG_DATA_W-1:0] data);
        return '{ROW_CFG, idx, data, bfcp_pkg::OP_ALLOC, '0, 2'd0,
                 '{NO_RES, NO_RES, NO_RES}};
    endfunction

    function automatic row_t req_row(input logic o, input logic [bfcp_pkg::CAP_W-1:0] s);
        return '{ROW_REQ, bfcp_pkg::CFG_CHUNK_CAPACITY, '0, o, s, 2'd0,
                 '{NO_RES, NO_RES, NO_RES}};
    endfunction

    function automatic row_t req_lit(input logic o, input logic [bfcp_pkg::CAP_W-1:0] s,
                                     input logic [1:0] n, input result_t a,
                                     input result_t b, input result_t c);
        return '{ROW_REQ, bfcp_pkg::CFG_CHUNK_CAPACITY, '0, o, s, n, '{a, b, c}};
    endfunction

    task automatic renumber_slots();
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            fill_lvl[i]  = '0;
            stripe_no[i] = base_stripe + bfcp_pkg::STRIPE_W'(i);
        end
        stripe_ctr = base_stripe + bfcp_pkg::STRIPE_W'(NUM_CHUNKS);
    endtask

    function automatic int fullest_slot();
        int b;
        b = 0;
        for (int i = 1; i < NUM_CHUNKS; i++)
        begin
            if (fill_lvl[i] > fill_lvl[b])
                b = i;
            else if (fill_lvl[i] == fill_lvl[b] && stripe_no[i] < stripe_no[b])
                b = i;
        end
        return b;
    endfunction

    task automatic retire_slot(input int s);
        pack_out[pack_n] = '{bfcp_pkg::KIND_FLUSH, stripe_no[s],
                             bfcp_pkg::SLOT_OUT_W'(s), '0, 1'b0};
        pack_n++;
        fill_lvl[s]  = '0;
        stripe_no[s] = stripe_ctr;
        stripe_ctr   = stripe_ctr + bfcp_pkg::STRIPE_W'(1);
    endtask

    task automatic pack_request(input logic op_i, input logic [bfcp_pkg::CAP_W-1:0] size_i);
        int                         s;
        logic [bfcp_pkg::CHK_W-1:0] after;
        logic [bfcp_pkg::CHK_W-1:0] best;
        logic                       hit;
        pack_n = 0;
        if (op_i == bfcp_pkg::OP_FLUSH)
        begin
            retire_slot(fullest_slot());
        end
        else
        begin
            s    = 0;
            best = '0;
            hit  = 1'b0;
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                after = bfcp_pkg::CHK_W'(fill_lvl[i]) + bfcp_pkg::CHK_W'(size_i);
                if (after <= bfcp_pkg::CHK_W'(cap_reg))
                begin
                    if (after > best)
                    begin
                        best = after;
                        s    = i;
                        hit  = 1'b1;
                    end
                    else if (after == best && hit && stripe_no[i] < stripe_no[s])
                    begin
                        s = i;
                    end
                end
            end
            if (!hit)
            begin
                s = fullest_slot();
                retire_slot(s);
            end
            pack_out[pack_n] = '{bfcp_pkg::KIND_GRANT, stripe_no[s],
                                 bfcp_pkg::SLOT_OUT_W'(s), fill_lvl[s], 1'b0};
            pack_n++;
            fill_lvl[s] = fill_lvl[s] + size_i;
            if (bfcp_pkg::CHK_W'(fill_lvl[s]) + bfcp_pkg::HEADER_BYTES +
                bfcp_pkg::CHK_W'(thr_reg) >= bfcp_pkg::CHK_W'(cap_reg))
                retire_slot(s);
        end
        pack_out[pack_n-1].last = 1'b1;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pack_events.size() != 0)
            @(posedge clk);
        repeat (NUM_CHUNKS + 6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bfcp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bfcp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bfcp_pkg::CFG_CHUNK_CAPACITY:  cap_reg = data[bfcp_pkg::CAP_W-1:0];
            bfcp_pkg::CFG_FLUSH_THRESHOLD: thr_reg = data[bfcp_pkg::THR_W-1:0];
            bfcp_pkg::CFG_FIRST_STRIPE_ID:
            begin
                base_stripe = data;
                renumber_slots();
            end
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_item(input logic op_i, input logic [bfcp_pkg::CAP_W-1:0] size_i,
                             input logic [1:0] n_want, input result_t [0:2] want);
        in_valid <= 1'b1;
        op       <= op_i;
        req_size <= size_i;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pack_request(op_i, size_i);
        if (n_want != 0)
        begin
            for (int k = 0; k < n_want; k++)
                pack_events.push_back(want[k]);
        end
        else
        begin
            for (int k = 0; k < pack_n; k++)
                pack_events.push_back(pack_out[k]);
        end
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 20)
        begin
            stall_left = gap_len() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pack_events.size() == 0)
            begin
                $error("unexpected result: kind %0d stripe_id %0h slot %0d", kind,
                       stripe_id, slot);
                fail_count++;
            end
            else
            begin
                exp_res = pack_events.pop_front();
                if (kind !== exp_res.kind)
                begin
                    $error("kind expected %0d actual %0d", exp_res.kind, kind);
                    fail_count++;
                end
                if (stripe_id !== exp_res.stripe_id)
                begin
                    $error("stripe_id expected %0h actual %0h", exp_res.stripe_id,
                           stripe_id);
                    fail_count++;
                end
                if (slot !== exp_res.slot)
                begin
                    $error("slot expected %0d actual %0d", exp_res.slot, slot);
                    fail_count++;
                end
                if (offset !== exp_res.offset)
                begin
                    $error("offset expected %0d actual %0d", exp_res.offset, offset);
                    fail_count++;
                end
                if (last !== exp_res.last)
                begin
                    $error("last expected %0d actual %0d", exp_res.last, last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $error("no transfer for %0d cycles", IDLE_LIMIT);
                $display("best_fit_chunk_packer verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [bfcp_pkg::CAP_W-1:0]    cap_val;
        logic [bfcp_pkg::THR_W-1:0]    thr_val;
        logic [bfcp_pkg::STRIPE_W-1:0] first_val;
        logic                          op_val;
        logic [bfcp_pkg::CAP_W-1:0]    size_val;
        int                            n_items;
        int                            hold_at;
        int                            lim;
        int                            r;
        int                            k;

        cap_reg     = bfcp_pkg::CAP_RESET;
        thr_reg     = '0;
        base_stripe = '0;
        renumber_slots();

        dir_tab = '{
            req_lit(bfcp_pkg::OP_FLUSH, 21'd0, 2'd1,
                    '{bfcp_pkg::KIND_FLUSH, 32'd0, 6'd0, 21'd0, 1'b1}, NO_RES, NO_RES),
            req_lit(bfcp_pkg::OP_FLUSH, 21'd0, 2'd1,
                    '{bfcp_pkg::KIND_FLUSH, 32'd1, 6'd1, 21'd0, 1'b1}, NO_RES, NO_RES),
            req_lit(bfcp_pkg::OP_ALLOC, 21'd100, 2'd1,
                    '{bfcp_pkg::KIND_GRANT, 32'd2, 6'd2, 21'd0, 1'b1}, NO_RES, NO_RES),
            req_lit(bfcp_pkg::OP_ALLOC, 21'd0, 2'd1,
                    '{bfcp_pkg::KIND_GRANT, 32'd2, 6'd2, 21'd100, 1'b1}, NO_RES, NO_RES),
            req_lit(bfcp_pkg::OP_ALLOC, 21'd4096, 2'd2,
                    '{bfcp_pkg::KIND_GRANT, 32'd3, 6'd3, 21'd0, 1'b0},
                    '{bfcp_pkg::KIND_FLUSH, 32'd3, 6'd3, 21'd0, 1'b1}, NO_RES),
            req_lit(bfcp_pkg::OP_ALLOC, 21'h1FFFFF, 2'd3,
                    '{bfcp_pkg::KIND_FLUSH, 32'd2, 6'd2, 21'd0, 1'b0},
                    '{bfcp_pkg::KIND_GRANT, 32'd11, 6'd2, 21'd0, 1'b0},
                    '{bfcp_pkg::KIND_FLUSH, 32'd11, 6'd2, 21'd0, 1'b1}),
            req_row(bfcp_pkg::OP_ALLOC, 21'd1),
            cfg_row(bfcp_pkg::CFG_FLUSH_THRESHOLD, 32'hFFFF_FFFF),
            req_row(bfcp_pkg::OP_ALLOC, 21'd5),
            cfg_row(bfcp_pkg::CFG_CHUNK_CAPACITY, 32'd0),
            req_row(bfcp_pkg::OP_ALLOC, 21'd0),
            req_row(bfcp_pkg::OP_ALLOC, 21'h10_0000),
            req_row(bfcp_pkg::OP_FLUSH, 21'h1FFFFF),
            cfg_row(CFG_UNUSED, 32'hA5A5_5A5A),
            cfg_row(bfcp_pkg::CFG_CHUNK_CAPACITY, 32'hFFFF_FFFF),
            cfg_row(bfcp_pkg::CFG_FLUSH_THRESHOLD, 32'd0),
            cfg_row(bfcp_pkg::CFG_FIRST_STRIPE_ID, 32'hFFFF_FFFE),
            req_lit(bfcp_pkg::OP_ALLOC, 21'd0, 2'd2,
                    '{bfcp_pkg::KIND_FLUSH, 32'd0, 6'd2, 21'd0, 1'b0},
                    '{bfcp_pkg::KIND_GRANT, 32'd6, 6'd2, 21'd0, 1'b1}, NO_RES),
            req_row(bfcp_pkg::OP_ALLOC, 21'h1FFFFF),
            req_row(bfcp_pkg::OP_FLUSH, 21'd0),
            req_row(bfcp_pkg::OP_ALLOC, 21'd7),
            req_row(bfcp_pkg::OP_FLUSH, 21'd0),
            cfg_row(bfcp_pkg::CFG_CHUNK_CAPACITY, 32'd1),
            req_row(bfcp_pkg::OP_ALLOC, 21'd1),
            req_row(bfcp_pkg::OP_ALLOC, 21'd2),
            cfg_row(bfcp_pkg::CFG_CHUNK_CAPACITY, 32'h0010_0000),
            cfg_row(bfcp_pkg::CFG_FLUSH_THRESHOLD, 32'h0000_8000),
            req_row(bfcp_pkg::OP_ALLOC, 21'd0)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int d = 0; d < N_DIR; d++)
        begin
            if (dir_tab[d].rk == ROW_CFG)
            begin
                wait_drained();
                write_reg(dir_tab[d].idx, dir_tab[d].data);
            end
            else
            begin
                send_item(dir_tab[d].op, dir_tab[d].size, dir_tab[d].n_want,
                          dir_tab[d].want);
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:       cap_val = bfcp_pkg::CAP_RESET;
                1:       cap_val = bfcp_pkg::CAP_W'($urandom_range(64, 8192));
                2:       cap_val = bfcp_pkg::CAP_W'(1048576);
                3:       cap_val = bfcp_pkg::CAP_W'($urandom_range(1, 40));
                4:       cap_val = bfcp_pkg::CAP_W'($urandom());
                default: cap_val = bfcp_pkg::CAP_W'($urandom_range(256, 4096));
            endcase
            lim = int'(cap_val >> 4);
            if (lim > 65535)
                lim = 65535;
            r = $urandom_range(0, 99);
            if (r < 50)
                thr_val = bfcp_pkg::THR_W'($urandom_range(0, lim));
            else if (r < 75)
                thr_val = '0;
            else if (r < 90)
                thr_val = bfcp_pkg::THR_W'($urandom());
            else
                thr_val = '1;
            first_val = (p == 2) ? 32'hFFFF_FFFC : $urandom();

            wait_drained();
            calm = (p == 1);
            write_reg(bfcp_pkg::CFG_CHUNK_CAPACITY, {11'($urandom()), cap_val});
            write_reg(bfcp_pkg::CFG_FLUSH_THRESHOLD, {16'($urandom()), thr_val});
            write_reg(bfcp_pkg::CFG_FIRST_STRIPE_ID, first_val);
            if (p == 4)
                write_reg(CFG_UNUSED, $urandom());

            n_items = 45 + $urandom_range(0, 10);
            hold_at = $urandom_range(5, 40);
            for (int j = 0; j < n_items; j++)
            begin
                if (j == hold_at)
                    wait_drained();
                op_val = ($urandom_range(0, 99) < 12) ? bfcp_pkg::OP_FLUSH
                                                      : bfcp_pkg::OP_ALLOC;
                r = $urandom_range(0, 99);
                if (op_val == bfcp_pkg::OP_FLUSH || r < 18)
                begin
                    size_val = bfcp_pkg::CAP_W'($urandom());
                end
                else if (r < 26)
                begin
                    size_val = '0;
                end
                else if (r < 41)
                begin
                    k = $urandom_range(0, NUM_CHUNKS - 1);
                    size_val = (cap_reg >= fill_lvl[k]) ? cap_reg - fill_lvl[k]
                                                        : bfcp_pkg::CAP_W'($urandom());
                end
                else if (r < 46)
                begin
                    size_val = cap_reg;
                end
                else
                begin
                    size_val = bfcp_pkg::CAP_W'($urandom_range(1, int'(cap_reg >> 2) + 1));
                end
                send_item(op_val, size_val, 2'd0, '0);
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (NUM_CHUNKS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("best_fit_chunk_packer verification clean");
        else
            $display("best_fit_chunk_packer verification failed");
        $finish;
    end

endmodule

[best_fit_chunk_packer.f]
hdl/bfcp_pkg.sv
hdl/bfcp_datapath.sv
hdl/bfcp_ctrl.sv
hdl/best_fit_chunk_packer.sv
verif/tb_best_fit_chunk_packer.sv
